FILE: src/ytpg_pkg.sv
package ytpg_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int RATE_W   = 9;
    localparam int TIME_W   = 16;
    localparam int NOW_W    = 32;
    localparam int YAW_W    = 20;
    localparam int SEG_W    = 3;

    typedef struct packed {
        logic             command;
        logic [NOW_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [YAW_W-1:0] yaw_millideg;
        logic [SEG_W-1:0]        segment;
    } t_out_item;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] CFG_FIRST_STEP_RATE    = 3'd0;
    localparam logic [2:0] CFG_SECOND_STEP_RATE   = 3'd1;
    localparam logic [2:0] CFG_FIRST_SMOOTH_RATE  = 3'd2;
    localparam logic [2:0] CFG_SECOND_SMOOTH_RATE = 3'd3;
    localparam logic [2:0] CFG_HOLD_TIME_MS       = 3'd4;
    localparam logic [2:0] CFG_STEP_PERIOD_MS     = 3'd5;

    localparam logic [RATE_W-1:0] RST_FIRST_STEP_RATE    = 9'd30;
    localparam logic [RATE_W-1:0] RST_SECOND_STEP_RATE   = 9'd90;
    localparam logic [RATE_W-1:0] RST_FIRST_SMOOTH_RATE  = 9'd10;
    localparam logic [RATE_W-1:0] RST_SECOND_SMOOTH_RATE = 9'd45;
    localparam logic [TIME_W-1:0] RST_HOLD_TIME_MS       = 16'd2000;
    localparam logic [TIME_W-1:0] RST_STEP_PERIOD_MS     = 16'd1000;

    localparam logic [SEG_W-1:0] SEG_HOLD    = 3'd0;
    localparam logic [SEG_W-1:0] SEG_STEP1   = 3'd1;
    localparam logic [SEG_W-1:0] SEG_STEP2   = 3'd2;
    localparam logic [SEG_W-1:0] SEG_SMOOTH1 = 3'd3;
    localparam logic [SEG_W-1:0] SEG_SMOOTH2 = 3'd4;

    localparam logic [RATE_W-1:0] FULL_TURN_DEG  = 9'd360;
    localparam logic [20:0]       FULL_TURN_MDEG = 21'd360000;
    localparam logic [20:0]       TWO_TURN_MDEG  = 21'd720000;
    localparam logic [15:0]       MDEG_PER_DEG   = 16'd1000;
    // dividends for the span divisions, pre-aligned to the divider's top bit
    localparam logic [31:0] TWO_TURN_DEG_ALIGNED  = 32'd720 << 22;
    localparam logic [31:0] TWO_TURN_MDEG_ALIGNED = 32'd720000 << 12;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_Q1,
        S_Q2,
        S_M1,
        S_M2,
        S_P1,
        S_P2,
        S_CYC,
        S_SEG1,
        S_SEG2,
        S_SEG3,
        S_SEG4,
        S_K,
        S_K2,
        S_K3,
        S_SM,
        S_DONE
    } t_state;

endpackage

FILE: src/yaw_test_profile_generator.sv
// Channel   | Handshake                  | Payload
// request   | i_in_valid / o_in_ready    | i_in_data  (ytpg_pkg::t_in_item)
// result    | o_out_valid / i_out_ready  | o_out_data (ytpg_pkg::t_out_item)
// config    | psel penable pwrite pready | paddr pwdata prdata (APB, 6 registers)
//
// Restart requests and ticks still inside the hold skip the divider.
// Other ticks make five passes through one shared radix-2 divider (10 + 10 + 20 +
// 20 + 32 steps), a sixth of 26 steps in step segments, plus multiply and compare steps.
// o_in_ready is high only while the sequencer is idle; one finished result may
// wait in the output register while the next request is taken.
// Synchronous active-low reset restores register defaults and clears the start latch.
module yaw_test_profile_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ytpg_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ytpg_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ytpg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ytpg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ytpg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    function automatic logic [8:0] f_clamp(input logic [8:0] r);
        if (r == 9'd0) begin
            return 9'd1;
        end else if (r > ytpg_pkg::FULL_TURN_DEG) begin
            return ytpg_pkg::FULL_TURN_DEG;
        end
        return r;
    endfunction

    // configuration registers
    logic [8:0]  r_fst_rate, r_snd_rate, r_fsm_rate, r_ssm_rate;
    logic [15:0] r_hold, r_period;
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    // sequencer and datapath
    ytpg_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [31:0] r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_prod;
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [9:0]  r_q1, n_q1, r_q2, n_q2, r_q, n_q;
    logic [19:0] r_sm1, n_sm1, r_sm2, n_sm2;
    logic [25:0] r_sp1, n_sp1, r_sp2, n_sp2;
    logic [26:0] r_cyc, n_cyc, r_ph, n_ph;
    logic [31:0] r_x, n_x;
    logic [8:0]  r_rate, n_rate;
    logic        r_neg, n_neg;
    logic [19:0] r_yaw, n_yaw;
    logic [2:0]  r_seg, n_seg;
    logic        r_started, n_started;
    logic [31:0] r_start, n_start;
    logic        r_out_valid, n_out_valid;
    ytpg_pkg::t_out_item r_out, n_out;

    logic        in_acc;
    logic [31:0] elapsed;
    logic [15:0] period;
    logic [8:0]  rs1, rs2, rm1, rm2;
    logic [32:0] div_shift;
    logic        div_fit;
    logic [26:0] ph_mod;
    logic [10:0] k_ext, per_ext, mult;
    logic [20:0] v_ext;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst_rate <= ytpg_pkg::RST_FIRST_STEP_RATE;
            r_snd_rate <= ytpg_pkg::RST_SECOND_STEP_RATE;
            r_fsm_rate <= ytpg_pkg::RST_FIRST_SMOOTH_RATE;
            r_ssm_rate <= ytpg_pkg::RST_SECOND_SMOOTH_RATE;
            r_hold     <= ytpg_pkg::RST_HOLD_TIME_MS;
            r_period   <= ytpg_pkg::RST_STEP_PERIOD_MS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ytpg_pkg::CFG_FIRST_STEP_RATE:    r_fst_rate <= pwdata[8:0];
                ytpg_pkg::CFG_SECOND_STEP_RATE:   r_snd_rate <= pwdata[8:0];
                ytpg_pkg::CFG_FIRST_SMOOTH_RATE:  r_fsm_rate <= pwdata[8:0];
                ytpg_pkg::CFG_SECOND_SMOOTH_RATE: r_ssm_rate <= pwdata[8:0];
                ytpg_pkg::CFG_HOLD_TIME_MS:       r_hold     <= pwdata[15:0];
                ytpg_pkg::CFG_STEP_PERIOD_MS:     r_period   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ytpg_pkg::CFG_FIRST_STEP_RATE:    prdata = {23'd0, r_fst_rate};
            ytpg_pkg::CFG_SECOND_STEP_RATE:   prdata = {23'd0, r_snd_rate};
            ytpg_pkg::CFG_FIRST_SMOOTH_RATE:  prdata = {23'd0, r_fsm_rate};
            ytpg_pkg::CFG_SECOND_SMOOTH_RATE: prdata = {23'd0, r_ssm_rate};
            ytpg_pkg::CFG_HOLD_TIME_MS:       prdata = {16'd0, r_hold};
            ytpg_pkg::CFG_STEP_PERIOD_MS:     prdata = {16'd0, r_period};
            default:                          prdata = '0;
        endcase
    end

    assign rs1    = f_clamp(r_fst_rate);
    assign rs2    = f_clamp(r_snd_rate);
    assign rm1    = f_clamp(r_fsm_rate);
    assign rm2    = f_clamp(r_ssm_rate);
    assign period = (r_period == 16'd0) ? 16'd1 : r_period;

    assign o_in_ready  = (r_state == ytpg_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign elapsed   = i_in_data.now_ms - (r_started ? r_start : i_in_data.now_ms);
    assign div_shift = {r_rem, r_quo[31]};
    assign div_fit   = (div_shift >= {1'b0, r_dvs});
    assign ph_mod    = r_rem[26:0];
    assign k_ext     = {1'b0, r_quo[9:0]};
    assign per_ext   = {2'b00, r_q[9:1]};
    assign v_ext     = {1'b0, r_prod[19:0]};

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_q1        = r_q1;
        n_q2        = r_q2;
        n_q         = r_q;
        n_sm1       = r_sm1;
        n_sm2       = r_sm2;
        n_sp1       = r_sp1;
        n_sp2       = r_sp2;
        n_cyc       = r_cyc;
        n_ph        = r_ph;
        n_x         = r_x;
        n_rate      = r_rate;
        n_neg       = r_neg;
        n_yaw       = r_yaw;
        n_seg       = r_seg;
        n_started   = r_started;
        n_start     = r_start;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mul_a       = '0;
        mul_b       = '0;
        mult        = '0;

        unique case (r_state)
            ytpg_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.command) begin
                        n_started = 1'b0;
                        n_start   = '0;
                        n_yaw     = '0;
                        n_seg     = ytpg_pkg::SEG_HOLD;
                        n_state   = ytpg_pkg::S_DONE;
                    end else begin
                        n_started = 1'b1;
                        if (!r_started) begin
                            n_start = i_in_data.now_ms;
                        end
                        n_x = elapsed - {16'd0, r_hold};
                        if (elapsed < {16'd0, r_hold}) begin
                            n_yaw   = '0;
                            n_seg   = ytpg_pkg::SEG_HOLD;
                            n_state = ytpg_pkg::S_DONE;
                        end else begin
                            n_rem   = '0;
                            n_quo   = ytpg_pkg::TWO_TURN_DEG_ALIGNED;
                            n_dvs   = {23'd0, rs1};
                            n_cnt   = 6'd10;
                            n_ret   = ytpg_pkg::S_Q1;
                            n_state = ytpg_pkg::S_DIV;
                        end
                    end
                end
            end
            ytpg_pkg::S_DIV: begin
                // one quotient bit per cycle, restoring
                n_quo = {r_quo[30:0], div_fit};
                n_rem = div_fit ? 32'(div_shift - {1'b0, r_dvs}) : div_shift[31:0];
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = r_ret;
                end
            end
            ytpg_pkg::S_Q1: begin
                n_q1    = r_quo[9:0];
                n_rem   = '0;
                n_quo   = ytpg_pkg::TWO_TURN_DEG_ALIGNED;
                n_dvs   = {23'd0, rs2};
                n_cnt   = 6'd10;
                n_ret   = ytpg_pkg::S_Q2;
                n_state = ytpg_pkg::S_DIV;
            end
            ytpg_pkg::S_Q2: begin
                n_q2    = r_quo[9:0];
                n_rem   = '0;
                n_quo   = ytpg_pkg::TWO_TURN_MDEG_ALIGNED;
                n_dvs   = {23'd0, rm1};
                n_cnt   = 6'd20;
                n_ret   = ytpg_pkg::S_M1;
                n_state = ytpg_pkg::S_DIV;
            end
            ytpg_pkg::S_M1: begin
                n_sm1   = r_quo[19:0];
                n_rem   = '0;
                n_quo   = ytpg_pkg::TWO_TURN_MDEG_ALIGNED;
                n_dvs   = {23'd0, rm2};
                n_cnt   = 6'd20;
                n_ret   = ytpg_pkg::S_M2;
                n_state = ytpg_pkg::S_DIV;
            end
            ytpg_pkg::S_M2: begin
                n_sm2   = r_quo[19:0];
                mul_a   = {22'd0, r_q1};
                mul_b   = period;
                n_state = ytpg_pkg::S_P1;
            end
            ytpg_pkg::S_P1: begin
                n_sp1   = r_prod[25:0];
                mul_a   = {22'd0, r_q2};
                mul_b   = period;
                n_state = ytpg_pkg::S_P2;
            end
            ytpg_pkg::S_P2: begin
                n_sp2   = r_prod[25:0];
                n_cyc   = {1'b0, r_sp1} + {1'b0, r_prod[25:0]};
                n_state = ytpg_pkg::S_CYC;
            end
            ytpg_pkg::S_CYC: begin
                // full cycle length is the divisor of the phase reduction
                n_rem   = '0;
                n_quo   = r_x;
                n_dvs   = {5'd0, r_cyc} + {12'd0, r_sm1} + {12'd0, r_sm2};
                n_cnt   = 6'd32;
                n_ret   = ytpg_pkg::S_SEG1;
                n_state = ytpg_pkg::S_DIV;
            end
            ytpg_pkg::S_SEG1: begin
                if (ph_mod < {1'b0, r_sp1}) begin
                    n_seg   = ytpg_pkg::SEG_STEP1;
                    n_rate  = rs1;
                    n_q     = r_q1;
                    n_rem   = '0;
                    n_quo   = {ph_mod[25:0], 6'd0};
                    n_dvs   = {16'd0, period};
                    n_cnt   = 6'd26;
                    n_ret   = ytpg_pkg::S_K;
                    n_state = ytpg_pkg::S_DIV;
                end else begin
                    n_ph    = ph_mod - {1'b0, r_sp1};
                    n_state = ytpg_pkg::S_SEG2;
                end
            end
            ytpg_pkg::S_SEG2: begin
                if (r_ph < {1'b0, r_sp2}) begin
                    n_seg   = ytpg_pkg::SEG_STEP2;
                    n_rate  = rs2;
                    n_q     = r_q2;
                    n_rem   = '0;
                    n_quo   = {r_ph[25:0], 6'd0};
                    n_dvs   = {16'd0, period};
                    n_cnt   = 6'd26;
                    n_ret   = ytpg_pkg::S_K;
                    n_state = ytpg_pkg::S_DIV;
                end else begin
                    n_ph    = r_ph - {1'b0, r_sp2};
                    n_state = ytpg_pkg::S_SEG3;
                end
            end
            ytpg_pkg::S_SEG3: begin
                if (r_ph < {7'd0, r_sm1}) begin
                    n_seg   = ytpg_pkg::SEG_SMOOTH1;
                    mul_a   = {5'd0, r_ph};
                    mul_b   = {7'd0, rm1};
                    n_state = ytpg_pkg::S_SM;
                end else begin
                    n_ph    = r_ph - {7'd0, r_sm1};
                    n_state = ytpg_pkg::S_SEG4;
                end
            end
            ytpg_pkg::S_SEG4: begin
                n_seg   = ytpg_pkg::SEG_SMOOTH2;
                mul_a   = {5'd0, r_ph};
                mul_b   = {7'd0, rm2};
                n_state = ytpg_pkg::S_SM;
            end
            ytpg_pkg::S_K: begin
                // rising half while the step index is below one full turn
                if (k_ext < per_ext) begin
                    mult  = k_ext + 11'd1;
                    n_neg = 1'b0;
                end else begin
                    mult  = k_ext - per_ext + 11'd1;
                    n_neg = 1'b1;
                end
                mul_a   = {21'd0, mult};
                mul_b   = {7'd0, r_rate};
                n_state = ytpg_pkg::S_K2;
            end
            ytpg_pkg::S_K2: begin
                mul_a   = r_prod[31:0];
                mul_b   = ytpg_pkg::MDEG_PER_DEG;
                n_state = ytpg_pkg::S_K3;
            end
            ytpg_pkg::S_K3: begin
                n_yaw   = r_neg ? 20'(ytpg_pkg::FULL_TURN_MDEG - v_ext) : r_prod[19:0];
                n_state = ytpg_pkg::S_DONE;
            end
            ytpg_pkg::S_SM: begin
                n_yaw   = (v_ext < ytpg_pkg::FULL_TURN_MDEG) ? r_prod[19:0]
                        : 20'(ytpg_pkg::TWO_TURN_MDEG - v_ext);
                n_state = ytpg_pkg::S_DONE;
            end
            ytpg_pkg::S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    n_out.yaw_millideg = r_yaw;
                    n_out.segment      = r_seg;
                    n_out_valid        = 1'b1;
                    n_state            = ytpg_pkg::S_IDLE;
                end
            end
            default: n_state = ytpg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ytpg_pkg::S_IDLE;
            r_ret       <= ytpg_pkg::S_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_prod <= mul_a * mul_b;
        r_q1   <= n_q1;
        r_q2   <= n_q2;
        r_q    <= n_q;
        r_sm1  <= n_sm1;
        r_sm2  <= n_sm2;
        r_sp1  <= n_sp1;
        r_sp2  <= n_sp2;
        r_cyc  <= n_cyc;
        r_ph   <= n_ph;
        r_x    <= n_x;
        r_rate <= n_rate;
        r_neg  <= n_neg;
        r_yaw  <= n_yaw;
        r_seg  <= n_seg;
        r_out  <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.command) |=> (!r_started && r_start == 32'd0))
        else $error("restart did not clear the start latch");

    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.segment == ytpg_pkg::SEG_HOLD)
            |-> (o_out_data.yaw_millideg == 20'sd0))
        else $error("hold result with nonzero yaw");

    a_smooth_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.segment == ytpg_pkg::SEG_SMOOTH1
                      || o_out_data.segment == ytpg_pkg::SEG_SMOOTH2))
            |-> !o_out_data.yaw_millideg[19])
        else $error("smooth segment gave negative yaw");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ytpg_pkg::S_DIV) |-> (r_cnt != 6'd0))
        else $error("divider running with zero step count");
`endif

endmodule
